// ===== sv/pls_pkg.sv =====
// shared types and constants for the priority load scheduler
`timescale 1ns / 1ps

package pls_pkg;

    localparam int QueueDepth  = 64;
    localparam int AssetCount  = 1024;
    localparam int QIdxW       = $clog2(QueueDepth);
    localparam int QCntW       = $clog2(QueueDepth + 1);
    localparam int AssetW      = 10;
    localparam int PrioW       = 20;
    localparam int MaxStarts   = 8;
    localparam int DivW        = 24;
    localparam logic [16:0] DistBias = 17'd26;

    localparam logic [1:0] CFG_BUDGET = 2'd0;
    localparam logic [1:0] CFG_COST   = 2'd1;
    localparam logic [1:0] CFG_STARTS = 2'd2;

    localparam logic [15:0] BudgetRst = 16'd4096;
    localparam logic [15:0] CostRst   = 16'd50;
    localparam logic [3:0]  StartsRst = 4'd3;

    typedef struct packed {
        logic             start;
        logic [DivW-1:0]  dividend;
        logic [16:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [PrioW-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== sv/priority_load_scheduler_unit.sv =====
// Priority load scheduler top level: request queue, serial divide, tick scan.
// A load request goes from accept through a flag read, a serial divide and a push before ready returns.
// A tick scans the queue once per pop, and each pop can wait on any output
// stall, up to 8 pops per tick; once an entry does not fit the rest of the queue is dropped.
// Synchronous active-low reset; after reset a pass clears the
// started flags of all assets, during which no request is accepted.
`timescale 1ns / 1ps

module priority_load_scheduler_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [9:0]  s_asset_id,
    input  logic [15:0] s_distance,
    input  logic [15:0] s_scale,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_started_id,
    output logic [31:0] m_memory_used,
    output logic        m_last_of_tick
);

    localparam int QIdxW = pls_pkg::QIdxW;
    localparam int QCntW = pls_pkg::QCntW;
    localparam int AW    = pls_pkg::AssetW;
    localparam int PW    = pls_pkg::PrioW;

    typedef enum logic [10:0] {
        ST_CLEAR  = 11'b00000000001,
        ST_IDLE   = 11'b00000000010,
        ST_FLAG   = 11'b00000000100,
        ST_DIV    = 11'b00000001000,
        ST_SCAN   = 11'b00000010000,
        ST_SCANW  = 11'b00000100000,
        ST_PICK   = 11'b00001000000,
        ST_MOVE   = 11'b00010000000,
        ST_MOVEW  = 11'b00100000000,
        ST_EMIT   = 11'b01000000000,
        ST_FLAGW  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] budget_reg;
    logic [15:0] cost_reg;
    logic [3:0]  starts_reg;

    // queue memory, entry = {priority, asset}
    logic [PW+AW-1:0] queue_mem [pls_pkg::QueueDepth];
    logic [PW+AW-1:0] q_rd_reg;
    logic [QIdxW-1:0] q_rd_addr;
    logic             q_wr_en;
    logic [QIdxW-1:0] q_wr_addr;
    logic [PW+AW-1:0] q_wr_data;

    logic started_mem [pls_pkg::AssetCount];
    logic             flag_rd_reg;
    logic             f_wr_en;
    logic [AW-1:0]    f_wr_addr;
    logic             f_wr_data;

    logic [QCntW-1:0] count_reg, count_next;
    logic [31:0]      used_reg, used_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [QIdxW-1:0] scan_reg, scan_next;
    logic [QIdxW-1:0] best_idx_reg, best_idx_next;
    logic [PW+AW-1:0] best_reg, best_next;
    logic             have_reg, have_next;
    logic [3:0]       done_reg, done_next;
    logic [3:0]       limit;

    logic [AW-1:0]    id_reg, id_next;
    logic [15:0]      dist_reg, dist_next;
    logic [15:0]      scale_reg, scale_next;

    logic        out_valid_reg, out_valid_next;
    logic [AW-1:0] out_id_reg, out_id_next;
    logic [31:0] out_used_reg, out_used_next;
    logic        out_last_reg, out_last_next;

    pls_pkg::div_req_t div_req;
    pls_pkg::div_rsp_t div_rsp;

    pls_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));

    logic        better;
    logic [32:0] need;
    logic        fits;
    logic        tick_end;

    assign limit = (starts_reg > 4'(pls_pkg::MaxStarts)) ? 4'(pls_pkg::MaxStarts)
                                                         : starts_reg;
    // outranks: higher priority, then lower asset
    assign better = !have_reg
        || (q_rd_reg[PW+AW-1:AW] > best_reg[PW+AW-1:AW])
        || ((q_rd_reg[PW+AW-1:AW] == best_reg[PW+AW-1:AW])
            && (q_rd_reg[AW-1:0] < best_reg[AW-1:0]));
    assign need = {1'b0, used_reg} + {17'd0, cost_reg};
    assign fits = need <= {17'd0, budget_reg};
    // cost is the same for every entry, so once one does not fit none will
    assign tick_end = (done_reg == limit) || (count_reg == '0) || !fits;

    always_ff @(posedge aclk) begin
        if (q_wr_en) begin
            queue_mem[q_wr_addr] <= q_wr_data;
        end
        q_rd_reg <= queue_mem[q_rd_addr];
        if (f_wr_en) begin
            started_mem[f_wr_addr] <= f_wr_data;
        end
        flag_rd_reg <= started_mem[s_asset_id];
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        used_next      = used_reg;
        clr_next       = clr_reg;
        scan_next      = scan_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        have_next      = have_reg;
        done_next      = done_reg;
        id_next        = id_reg;
        dist_next      = dist_reg;
        scale_next     = scale_reg;
        out_valid_next = out_valid_reg;
        out_id_next    = out_id_reg;
        out_used_next  = out_used_reg;
        out_last_next  = out_last_reg;
        s_ready        = 1'b0;
        q_rd_addr      = scan_reg;
        q_wr_en        = 1'b0;
        q_wr_addr      = count_reg[QIdxW-1:0];
        q_wr_data      = {div_rsp.quotient, id_reg};
        f_wr_en        = 1'b0;
        f_wr_addr      = clr_reg;
        f_wr_data      = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = {scale_reg, 8'd0};
        div_req.divisor  = {1'b0, dist_reg} + pls_pkg::DistBias;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                f_wr_en  = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(pls_pkg::AssetCount - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && s_ready) begin
                    id_next    = s_asset_id;
                    dist_next  = s_distance;
                    scale_next = s_scale;
                    if (!s_req_type) begin
                        state_next = ST_FLAG;
                    end else if (limit != 4'd0 && count_reg != '0) begin
                        done_next     = '0;
                        scan_next     = '0;
                        have_next     = 1'b0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_FLAG: begin
                // flag read data for the accepted asset is now registered
                if (flag_rd_reg || count_reg >= QCntW'(pls_pkg::QueueDepth)) begin
                    state_next = ST_IDLE;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    q_wr_en    = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                state_next = ST_SCANW;
            end
            ST_SCANW: begin
                if (better) begin
                    best_next     = q_rd_reg;
                    best_idx_next = scan_reg;
                    have_next     = 1'b1;
                end
                if (QCntW'(scan_reg) == count_reg - 1'b1) begin
                    state_next = ST_PICK;
                end else begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_PICK: begin
                // last entry fills the hole
                scan_next  = QIdxW'(count_reg - 1'b1);
                count_next = count_reg - 1'b1;
                state_next = ST_MOVE;
            end
            ST_MOVE: begin
                state_next = ST_MOVEW;
            end
            ST_MOVEW: begin
                q_wr_en   = 1'b1;
                q_wr_addr = best_idx_reg;
                q_wr_data = q_rd_reg;
                if (fits) begin
                    used_next = need[31:0];
                    f_wr_en   = 1'b1;
                    f_wr_addr = best_reg[AW-1:0];
                    f_wr_data = 1'b1;
                    done_next = done_reg + 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    // no later entry can fit either, the tick drops them all
                    count_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!out_valid_reg) begin
                    out_valid_next = 1'b1;
                    out_id_next    = best_reg[AW-1:0];
                    out_used_next  = used_reg;
                    out_last_next  = tick_end;
                    scan_next      = '0;
                    have_next      = 1'b0;
                    if (!fits && done_reg != limit) begin
                        count_next = '0;
                    end
                    state_next     = tick_end ? ST_IDLE : ST_SCAN;
                end
            end
            ST_FLAGW: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            count_reg     <= '0;
            used_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
            have_reg      <= 1'b0;
            budget_reg    <= pls_pkg::BudgetRst;
            cost_reg      <= pls_pkg::CostRst;
            starts_reg    <= pls_pkg::StartsRst;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            used_reg      <= used_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            done_reg      <= done_next;
            have_reg      <= have_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    pls_pkg::CFG_BUDGET: budget_reg <= cfg_data;
                    pls_pkg::CFG_COST:   cost_reg   <= cfg_data;
                    pls_pkg::CFG_STARTS: starts_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
        end
        scan_reg     <= scan_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        id_reg       <= id_next;
        dist_reg     <= dist_next;
        scale_reg    <= scale_next;
        out_id_reg   <= out_id_next;
        out_used_reg <= out_used_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_started_id   = out_id_reg;
    assign m_memory_used  = out_used_reg;
    assign m_last_of_tick = out_last_reg;

    count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCntW'(pls_pkg::QueueDepth))
        else $error("queue count overflow");
    used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !$past(out_valid_reg)) |-> out_used_reg <= {16'd0, budget_reg})
        else $error("charged memory exceeds budget");
    no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    starts_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg <= 4'(pls_pkg::MaxStarts))
        else $error("too many starts in one tick");

endmodule

// ===== sv/pls_divider.sv =====
// restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps

module pls_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  pls_pkg::div_req_t req,
    output pls_pkg::div_rsp_t rsp
);

    logic [23:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [16:0] dsr_reg, dsr_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [17:0] trial;
    logic [17:0] diff;

    always_comb begin
        trial = {rem_reg, quo_reg[23]};
        diff  = trial - {1'b0, dsr_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 5'd24;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[17]) begin
                rem_next = diff[16:0];
                quo_next = {quo_reg[22:0], 1'b1};
            end else begin
                rem_next = trial[16:0];
                quo_next = {quo_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg[pls_pkg::PrioW-1:0];

    cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != 5'd0)
        else $error("divider count zero while busy");
    done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("divider done held");
    start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg)
        else $error("divider did not start");

endmodule

// ===== tb/priority_load_scheduler_unit_tb.sv =====
// testbench for the priority load scheduler: directed table, random traffic, queue-order check
`timescale 1ns / 1ps

module priority_load_scheduler_unit_tb;

    localparam logic ReqLoad = 1'b0;
    localparam logic ReqTick = 1'b1;
    localparam int CycleLimit = 2000000;
    localparam int DrainWait = 900;

    typedef struct {
        logic [9:0]  id;
        logic [31:0] used;
        logic        last;
    } start_t;

    typedef struct {
        logic        req_type;
        logic [9:0]  asset_id;
        logic [15:0] distance;
        logic [15:0] scale;
        int          n_typed;     // -1: check against predictor only
        logic [9:0]  typed_id;
    } row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic [1:0]  cfg_index = pls_pkg::CFG_BUDGET;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 0;
    logic        s_ready;
    logic        s_req_type = 0;
    logic [9:0]  s_asset_id = '0;
    logic [15:0] s_distance = '0;
    logic [15:0] s_scale = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [9:0]  m_started_id;
    logic [31:0] m_memory_used;
    logic        m_last_of_tick;

    // predictor state
    logic [15:0] budget_q;
    logic [15:0] cost_q;
    logic [3:0]  starts_q;
    logic [19:0] heap_prio[$];
    logic [9:0]  heap_asset[$];
    bit          started_flag[1024];
    logic [31:0] used_mb;

    start_t pending_starts[$];
    int errors = 0;
    int cycles = 0;
    int n_loads = 0, n_ticks = 0, n_starts = 0;
    int last_n = 0;

    priority_load_scheduler_unit u_top (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout at %0t", $time);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // update prediction for one accepted request
    task automatic predict_request(input logic rt, input logic [9:0] aid,
                                   input logic [15:0] dist_v, input logic [15:0] scl);
        logic [31:0] prio;
        int limit, n, best;
        logic [32:0] need;
        logic [9:0] a;
        start_t s;
        last_n = 0;
        if (rt == ReqLoad) begin
            n_loads++;
            if (started_flag[aid] || heap_prio.size() >= pls_pkg::QueueDepth) return;
            prio = ({16'd0, scl} << 8) / ({16'd0, dist_v} + 32'd26);
            heap_prio.push_back(prio[19:0]);
            heap_asset.push_back(aid);
        end else begin
            n_ticks++;
            limit = starts_q > pls_pkg::MaxStarts ? pls_pkg::MaxStarts : starts_q;
            n = 0;
            while (n < limit && heap_prio.size() > 0) begin
                best = 0;
                for (int i = 1; i < heap_prio.size(); i++)
                    if (heap_prio[i] > heap_prio[best] ||
                        (heap_prio[i] == heap_prio[best] && heap_asset[i] < heap_asset[best]))
                        best = i;
                a = heap_asset[best];
                heap_prio.delete(best);
                heap_asset.delete(best);
                need = {1'b0, used_mb} + {17'd0, cost_q};
                if (need > {17'd0, budget_q}) continue;
                used_mb = need[31:0];
                started_flag[a] = 1;
                s.id = a; s.used = used_mb; s.last = 0;
                pending_starts.push_back(s);
                n++;
            end
            if (n > 0) pending_starts[pending_starts.size() - 1].last = 1;
            last_n = n;
        end
    endtask

    // valid is only dropped when a gap follows, so back to back rows keep it high
    task automatic send_request(input logic rt, input logic [9:0] aid,
                                input logic [15:0] dist_v, input logic [15:0] scl);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1; s_req_type <= rt; s_asset_id <= aid;
        s_distance <= dist_v; s_scale <= scl;
        do @(posedge aclk); while (!s_ready);
        predict_request(rt, aid, dist_v, scl);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1; cfg_index <= idx; cfg_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 0;
        case (idx)
            pls_pkg::CFG_BUDGET: budget_q = val;
            pls_pkg::CFG_COST:   cost_q = val;
            default:             starts_q = val[3:0];
        endcase
    endtask

    // let the block settle before touching registers
    task automatic wait_idle();
        int guard;
        guard = 0;
        s_valid <= 0;
        while (pending_starts.size() > 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (DrainWait) @(negedge aclk);
    endtask

    // result side: random stall per request
    initial begin
        int stall;
        start_t e;
        forever begin
            stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 13);
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1;
            do @(posedge aclk); while (!(m_valid && aresetn));
            n_starts++;
            if (pending_starts.size() == 0) begin
                $display("%0t: unexpected start id=%0d used=%0d", $time,
                         m_started_id, m_memory_used);
                errors++;
            end else begin
                e = pending_starts.pop_front();
                if (m_started_id !== e.id || m_memory_used !== e.used ||
                    m_last_of_tick !== e.last) begin
                    $display("%0t: mismatch expected id=%0d used=%0d last=%0d,",
                             $time, e.id, e.used, e.last);
                    $display("    got id=%0d used=%0d last=%0d",
                             m_started_id, m_memory_used, m_last_of_tick);
                    errors++;
                end
            end
        end
    end

    row_t directed[$];
    row_t typed_row;

    function automatic row_t mk(logic rt, logic [9:0] aid, logic [15:0] dist_v,
                                logic [15:0] scl, int nt, logic [9:0] tid);
        row_t r;
        r.req_type = rt; r.asset_id = aid; r.distance = dist_v; r.scale = scl;
        r.n_typed = nt; r.typed_id = tid;
        return r;
    endfunction

    // random phase: loads with ticks mixed in, ids mostly from 0 to id_span, then a final tick
    task automatic random_phase(input int n_items, input int id_span);
        int k;
        logic [15:0] d, s;
        logic [9:0] aid;
        for (k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 5) == 0) begin
                send_request(ReqTick, 10'($urandom), 16'($urandom), 16'($urandom));
            end else begin
                aid = $urandom_range(0, 4) == 0 ? 10'($urandom)
                                                : 10'($urandom_range(0, id_span));
                case ($urandom_range(0, 3))
                    0: begin d = 16'hffff; s = 16'($urandom); end
                    1: begin d = 16'($urandom_range(0, 40)); s = 16'($urandom_range(0, 40)); end
                    default: begin d = 16'($urandom); s = 16'($urandom); end
                endcase
                send_request(ReqLoad, aid, d, s);
            end
        end
        send_request(ReqTick, '0, '0, '0);
    endtask

    initial begin
        budget_q = pls_pkg::BudgetRst; cost_q = pls_pkg::CostRst;
        starts_q = pls_pkg::StartsRst; used_mb = 0;
        repeat (4) @(negedge aclk);
        aresetn <= 1;

        // directed rows at reset settings; typed results where obvious
        directed.push_back(mk(ReqTick, 10'd0, 16'd0, 16'd0, 0, 10'd0));   // empty tick
        directed.push_back(mk(ReqLoad, 10'd1023, 16'hffff, 16'hffff, -1, 10'd0));
        directed.push_back(mk(ReqLoad, 10'd0, 16'h0000, 16'hffff, -1, 10'd0)); // max priority
        directed.push_back(mk(ReqTick, 10'd0, 16'd0, 16'd0, 2, 10'd0));
        directed.push_back(mk(ReqLoad, 10'd0, 16'h0100, 16'h0100, -1, 10'd0)); // already started
        directed.push_back(mk(ReqLoad, 10'd7, 16'h0100, 16'h0100, -1, 10'd0));
        directed.push_back(mk(ReqLoad, 10'd5, 16'h0100, 16'h0100, -1, 10'd0)); // tie, lower id
        directed.push_back(mk(ReqLoad, 10'd9, 16'h0000, 16'h0000, -1, 10'd0)); // zero priority
        directed.push_back(mk(ReqLoad, 10'd9, 16'h0000, 16'h0000, -1, 10'd0)); // duplicate
        directed.push_back(mk(ReqTick, 10'd0, 16'd0, 16'd0, -1, 10'd0));
        directed.push_back(mk(ReqTick, 10'd0, 16'd0, 16'd0, -1, 10'd0));
        for (int i = 0; i < directed.size(); i++) begin
            typed_row = directed[i];
            send_request(typed_row.req_type, typed_row.asset_id,
                         typed_row.distance, typed_row.scale);
            if (typed_row.n_typed >= 0) begin
                if (last_n != typed_row.n_typed) begin
                    $display("%0t: mismatch expected %0d starts got predicted %0d",
                             $time, typed_row.n_typed, last_n);
                    errors++;
                end else if (last_n > 0 &&
                             pending_starts[pending_starts.size() - last_n].id
                             !== typed_row.typed_id) begin
                    $display("%0t: mismatch expected first id=%0d got predicted %0d",
                             $time, typed_row.typed_id,
                             pending_starts[pending_starts.size() - last_n].id);
                    errors++;
                end
            end
        end
        wait_idle();

        // queue full, then tick limit zero and large
        write_reg(pls_pkg::CFG_STARTS, 16'd0);
        for (int i = 0; i < 66; i++) send_request(ReqLoad, 10'(100 + i), 16'(i), 16'h0800);
        send_request(ReqTick, 10'd0, 16'd0, 16'd0);
        wait_idle();
        write_reg(pls_pkg::CFG_STARTS, 16'd15);
        write_reg(pls_pkg::CFG_COST, 16'd0);
        send_request(ReqTick, 10'd0, 16'd0, 16'd0);
        wait_idle();

        // budget extremes: zero budget, then full budget, both at maximal cost
        write_reg(pls_pkg::CFG_BUDGET, 16'd0);
        write_reg(pls_pkg::CFG_COST, 16'hffff);
        random_phase(30, 1023);
        wait_idle();
        write_reg(pls_pkg::CFG_BUDGET, 16'hffff);
        random_phase(30, 1023);
        wait_idle();

        for (int ph = 0; ph < 10; ph++) begin
            write_reg(pls_pkg::CFG_BUDGET, 16'($urandom));
            write_reg(pls_pkg::CFG_COST, ph % 3 == 0 ? 16'd1 : 16'($urandom_range(0, 300)));
            write_reg(pls_pkg::CFG_STARTS, 16'($urandom_range(1, 8)));
            random_phase(20, ph % 2 ? 63 : 1023);
            wait_idle();
        end
        wait_idle();
        if (pending_starts.size() != 0) begin
            $display("%0t: %0d expected starts never arrived", $time, pending_starts.size());
            errors++;
        end
        $display("covered %0d load requests, %0d ticks, %0d starts checked",
                 n_loads, n_ticks, n_starts);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ===== priority_load_scheduler_unit.f =====
sv/pls_pkg.sv
sv/pls_divider.sv
sv/priority_load_scheduler_unit.sv
tb/priority_load_scheduler_unit_tb.sv
